// ----- hdl/hcbd_pkg.sv -----
`default_nettype none

package hcbd_pkg;

    localparam int LINE_MAX_DEFAULT = 8;
    localparam int QUEUE_DEPTH = 2;
    localparam int ACC_W = 28;
    localparam int TOTAL_W = 32;
    localparam logic [TOTAL_W-1:0] MAX_TOTAL_RESET = 32'd524288;
    localparam logic [7:0] CHAR_LF = 8'h0A;

    localparam logic [2:0] ST_BUSY = 3'd0;
    localparam logic [2:0] ST_DATA = 3'd1;
    localparam logic [2:0] ST_EMPTY = 3'd2;
    localparam logic [2:0] ST_LONG = 3'd3;
    localparam logic [2:0] ST_HEX = 3'd4;
    localparam logic [2:0] ST_BIG = 3'd5;

    typedef enum logic [2:0]
    {
        PH_SIZE = 3'b001,
        PH_DATA = 3'b010,
        PH_DONE = 3'b100
    } phase_t;

    typedef struct packed
    {
        logic [7:0] data;
        logic       is_lf;
        logic       is_hex;
        logic [3:0] digit;
    } class_t;

    typedef struct packed
    {
        logic [7:0] payload_byte;
        logic       payload_valid;
        logic [2:0] status;
        logic       finished;
    } result_t;

endpackage

`default_nettype wire

// ----- hdl/hcbd_queue.sv -----
`default_nettype none

module hcbd_queue #(
    parameter int WIDTH = 8,
    parameter int DEPTH = hcbd_pkg::QUEUE_DEPTH
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             push,
    input  wire logic [WIDTH-1:0] wr_data,
    output logic                  full,
    input  wire logic             pop,
    output logic      [WIDTH-1:0] rd_data,
    output logic                  empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             do_push;
    logic             do_pop;

    assign full = (count_reg == CNT_W'(DEPTH));
    assign empty = (count_reg == '0);
    assign do_push = push && !full;
    assign do_pop = pop && !empty;
    assign rd_data = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        count_next = count_reg + CNT_W'(do_push) - CNT_W'(do_pop);
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= wr_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg <= count_next;
        end
    end

endmodule

`default_nettype wire

// ----- hdl/hcbd_front.sv -----
`default_nettype none

module hcbd_front #(
    parameter int QUEUE_DEPTH = hcbd_pkg::QUEUE_DEPTH
) (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           push,
    input  wire logic [7:0]     rx_byte,
    output logic                full,
    input  wire logic           cls_pop,
    output logic                cls_valid,
    output hcbd_pkg::class_t    cls_out
);

    localparam int CLS_W = $bits(hcbd_pkg::class_t);

    hcbd_pkg::class_t cls_in;
    logic [CLS_W-1:0] q_rd_data;
    logic             q_empty;

    always_comb
    begin
        cls_in.data = rx_byte;
        cls_in.is_lf = (rx_byte == hcbd_pkg::CHAR_LF);
        cls_in.is_hex = 1'b0;
        cls_in.digit = 4'd0;
        if (rx_byte inside {[8'h30:8'h39]})
        begin
            cls_in.is_hex = 1'b1;
            cls_in.digit = rx_byte[3:0];
        end
        else if (rx_byte inside {[8'h61:8'h66], [8'h41:8'h46]})
        begin
            // Letters a-f and A-F share low nibbles 1 through 6.
            cls_in.is_hex = 1'b1;
            cls_in.digit = rx_byte[3:0] + 4'd9;
        end
    end

    hcbd_queue #(
        .WIDTH (CLS_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_cls_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (push),
        .wr_data (cls_in),
        .full    (full),
        .pop     (cls_pop),
        .rd_data (q_rd_data),
        .empty   (q_empty)
    );

    assign cls_valid = !q_empty;
    assign cls_out = hcbd_pkg::class_t'(q_rd_data);

endmodule

`default_nettype wire

// ----- hdl/hcbd_back.sv -----
`default_nettype none

module hcbd_back #(
    parameter int LINE_MAX = hcbd_pkg::LINE_MAX_DEFAULT
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          cfg_valid,
    input  wire logic [hcbd_pkg::TOTAL_W-1:0]  cfg_data,
    input  wire logic                          in_valid,
    input  wire hcbd_pkg::class_t              in_cls,
    output logic                               in_pop,
    input  wire logic                          res_full,
    output logic                               res_push,
    output hcbd_pkg::result_t                  res
);

    localparam int LC_W = $clog2(LINE_MAX + 1);
    localparam int ACC_W = hcbd_pkg::ACC_W;
    localparam int TOTAL_W = hcbd_pkg::TOTAL_W;

    hcbd_pkg::phase_t     phase_reg;
    hcbd_pkg::phase_t     phase_next;
    logic [LC_W-1:0]      line_count_reg;
    logic [LC_W-1:0]      line_count_next;
    logic [ACC_W-1:0]     acc_reg;
    logic [ACC_W-1:0]     acc_next;
    logic [3:0]           held_digit_reg;
    logic [3:0]           held_digit_next;
    logic                 held_hex_reg;
    logic                 held_hex_next;
    logic                 bad_reg;
    logic                 bad_next;
    logic [ACC_W-1:0]     chunk_reg;
    logic [ACC_W-1:0]     chunk_next;
    logic [TOTAL_W-1:0]   total_reg;
    logic [TOTAL_W-1:0]   total_next;
    logic [2:0]           final_reg;
    logic [2:0]           final_next;
    logic [TOTAL_W-1:0]   max_reg;
    logic [TOTAL_W:0]     sum;
    logic                 step;

    assign step = in_valid && !res_full;
    assign in_pop = step;
    assign res_push = step;
    assign sum = {1'b0, total_reg} + {{(TOTAL_W + 1 - ACC_W){1'b0}}, acc_reg};

    always_comb
    begin
        phase_next = phase_reg;
        line_count_next = line_count_reg;
        acc_next = acc_reg;
        held_digit_next = held_digit_reg;
        held_hex_next = held_hex_reg;
        bad_next = bad_reg;
        chunk_next = chunk_reg;
        total_next = total_reg;
        final_next = final_reg;
        if (step)
        begin
            case (phase_reg)
                hcbd_pkg::PH_SIZE:
                begin
                    if (in_cls.is_lf)
                    begin
                        if (line_count_reg <= LC_W'(1))
                        begin
                            line_count_next = '0;
                            acc_next = '0;
                            held_digit_next = 4'd0;
                            held_hex_next = 1'b0;
                            bad_next = 1'b0;
                        end
                        else if (bad_reg)
                        begin
                            phase_next = hcbd_pkg::PH_DONE;
                            final_next = hcbd_pkg::ST_HEX;
                        end
                        else if (acc_reg == '0)
                        begin
                            phase_next = hcbd_pkg::PH_DONE;
                            final_next = (total_reg == '0) ? hcbd_pkg::ST_EMPTY
                                                           : hcbd_pkg::ST_DATA;
                        end
                        else
                        begin
                            total_next = sum[TOTAL_W] ? '1 : sum[TOTAL_W-1:0];
                            if (sum > {1'b0, max_reg})
                            begin
                                phase_next = hcbd_pkg::PH_DONE;
                                final_next = hcbd_pkg::ST_BIG;
                            end
                            else
                            begin
                                chunk_next = acc_reg;
                                line_count_next = '0;
                                acc_next = '0;
                                held_digit_next = 4'd0;
                                held_hex_next = 1'b0;
                                bad_next = 1'b0;
                                phase_next = hcbd_pkg::PH_DATA;
                            end
                        end
                    end
                    else if (line_count_reg >= LC_W'(LINE_MAX))
                    begin
                        phase_next = hcbd_pkg::PH_DONE;
                        final_next = hcbd_pkg::ST_LONG;
                    end
                    else
                    begin
                        // The previous character is folded only once a later one proves
                        // it is not the CR that closes the line.
                        if (line_count_reg != '0)
                        begin
                            acc_next = {acc_reg[ACC_W-5:0], held_digit_reg};
                            bad_next = bad_reg || !held_hex_reg;
                        end
                        held_digit_next = in_cls.digit;
                        held_hex_next = in_cls.is_hex;
                        line_count_next = line_count_reg + 1'b1;
                    end
                end
                hcbd_pkg::PH_DATA:
                begin
                    chunk_next = chunk_reg - 1'b1;
                    if (chunk_reg == ACC_W'(1))
                    begin
                        phase_next = hcbd_pkg::PH_SIZE;
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    always_comb
    begin
        res.payload_valid = (phase_reg == hcbd_pkg::PH_DATA);
        res.payload_byte = res.payload_valid ? in_cls.data : 8'd0;
        res.finished = (phase_next == hcbd_pkg::PH_DONE);
        res.status = res.finished ? final_next : hcbd_pkg::ST_BUSY;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= hcbd_pkg::PH_SIZE;
            line_count_reg <= '0;
            acc_reg <= '0;
            held_digit_reg <= 4'd0;
            held_hex_reg <= 1'b0;
            bad_reg <= 1'b0;
            chunk_reg <= '0;
            total_reg <= '0;
            final_reg <= hcbd_pkg::ST_BUSY;
            max_reg <= hcbd_pkg::MAX_TOTAL_RESET;
        end
        else
        begin
            phase_reg <= phase_next;
            line_count_reg <= line_count_next;
            acc_reg <= acc_next;
            held_digit_reg <= held_digit_next;
            held_hex_reg <= held_hex_next;
            bad_reg <= bad_next;
            chunk_reg <= chunk_next;
            total_reg <= total_next;
            final_reg <= final_next;
            if (cfg_valid)
            begin
                max_reg <= cfg_data;
            end
        end
    end

endmodule

`default_nettype wire

// ----- hdl/http_chunked_body_decoder.sv -----
`default_nettype none

// Decodes an HTTP/1.1 chunked body at one byte per clock cycle while the result queue has
// room, with one result item per input byte. The front part classifies each byte into a
// short queue, and the back part applies it to the decoder state and writes the result
// into an output queue, so a byte is registered in the class queue and then in the result
// queue on its way out. Both queues hold QUEUE_DEPTH items, and either side may stall
// without stopping the other until its queue fills. The limit register is written through
// the cfg channel, which is always ready; write it only while no item is in flight.
module http_chunked_body_decoder #(
    parameter int LINE_MAX = hcbd_pkg::LINE_MAX_DEFAULT,
    parameter int QUEUE_DEPTH = hcbd_pkg::QUEUE_DEPTH
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        push,
    output logic             full,
    input  wire logic [7:0]  rx_byte,
    output logic             empty,
    input  wire logic        pop,
    output logic      [7:0]  payload_byte,
    output logic             payload_valid,
    output logic      [2:0]  status,
    output logic             finished,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [31:0] cfg_data
);

    localparam int RES_W = $bits(hcbd_pkg::result_t);

    hcbd_pkg::class_t  cls;
    logic              cls_valid;
    logic              cls_pop;
    logic              res_full;
    logic              res_push;
    hcbd_pkg::result_t res_in;
    hcbd_pkg::result_t res_out;
    logic [RES_W-1:0]  res_rd_data;

    assign cfg_ready = 1'b1;

    hcbd_front #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .rx_byte   (rx_byte),
        .full      (full),
        .cls_pop   (cls_pop),
        .cls_valid (cls_valid),
        .cls_out   (cls)
    );

    hcbd_back #(
        .LINE_MAX (LINE_MAX)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid && cfg_ready),
        .cfg_data  (cfg_data),
        .in_valid  (cls_valid),
        .in_cls    (cls),
        .in_pop    (cls_pop),
        .res_full  (res_full),
        .res_push  (res_push),
        .res       (res_in)
    );

    hcbd_queue #(
        .WIDTH (RES_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_res_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (res_push),
        .wr_data (res_in),
        .full    (res_full),
        .pop     (pop),
        .rd_data (res_rd_data),
        .empty   (empty)
    );

    assign res_out = hcbd_pkg::result_t'(res_rd_data);
    assign payload_byte = res_out.payload_byte;
    assign payload_valid = res_out.payload_valid;
    assign status = res_out.status;
    assign finished = res_out.finished;

    a_payload_not_finished: assert property (
        @(posedge clk) disable iff (!rst_n)
        (!empty && payload_valid) |-> !finished
    ) else $error("Payload byte reported together with finished.");

    a_finished_has_code: assert property (
        @(posedge clk) disable iff (!rst_n)
        (!empty && finished) |-> (status != hcbd_pkg::ST_BUSY)
    ) else $error("Finished result carries the busy status.");

    a_busy_has_no_code: assert property (
        @(posedge clk) disable iff (!rst_n)
        (!empty && !finished) |-> (status == hcbd_pkg::ST_BUSY)
    ) else $error("Unfinished result carries a final status.");

    a_no_stray_payload: assert property (
        @(posedge clk) disable iff (!rst_n)
        (!empty && !payload_valid) |-> (payload_byte == 8'd0)
    ) else $error("Payload byte is nonzero on a non-payload result.");

endmodule

`default_nettype wire

// ----- verif/http_chunked_body_decoder_tb.sv -----
`timescale 1ns / 100ps

module http_chunked_body_decoder_tb;

    localparam int LINE_LIMIT = hcbd_pkg::LINE_MAX_DEFAULT;
    localparam int BODY_ITEMS = 1250;
    localparam int STALL_LIMIT = 4000;
    localparam int HOLD_AFTER_POPS = 300;
    localparam int HOLD_CYCLES = 60;
    localparam int PRINT_CAP = 100;

    typedef enum logic [1:0]
    {
        OP_BYTE,
        OP_DRAIN,
        OP_LIMIT
    } stim_kind_t;

    typedef struct
    {
        stim_kind_t  kind;
        logic [31:0] value;
    } stim_op_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        push = 1'b0;
    logic        full;
    logic [7:0]  rx_byte = 8'h00;
    logic        empty;
    logic        pop = 1'b0;
    logic [7:0]  payload_byte;
    logic        payload_valid;
    logic [2:0]  status;
    logic        finished;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [31:0] cfg_data = 32'h0;

    stim_op_t           body_stream[$];
    hcbd_pkg::result_t  pending_results[$];
    int          fault_count = 0;
    int          stall_cycles = 0;
    logic        quiet_tail = 1'b0;
    int          send_gap = 0;
    int          recv_wait = 0;
    int          pops_seen = 0;
    bit          held_once = 1'b0;

    // Stimulus bookkeeping.
    int unsigned gen_total = 0;
    int          body_bytes = 0;

    // Decoder state as predicted.
    hcbd_pkg::phase_t dec_phase = hcbd_pkg::PH_SIZE;
    logic [4:0]  line_len = '0;
    logic [27:0] size_acc = '0;
    logic [7:0]  held_char = '0;
    logic        bad_digit = 1'b0;
    logic [27:0] chunk_left = '0;
    logic [31:0] total_len = '0;
    logic [2:0]  end_status = hcbd_pkg::ST_BUSY;
    logic [31:0] limit_reg = hcbd_pkg::MAX_TOTAL_RESET;

    http_chunked_body_decoder dut
    (
        .clk(clk),
        .rst_n(rst_n),
        .push(push),
        .full(full),
        .rx_byte(rx_byte),
        .empty(empty),
        .pop(pop),
        .payload_byte(payload_byte),
        .payload_valid(payload_valid),
        .status(status),
        .finished(finished),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_data(cfg_data)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        if (fault_count < PRINT_CAP)
        begin
            $display("mismatch: %s: got 0x%0h, expected 0x%0h at %0t", what, got, want,
                     $time);
        end
        fault_count++;
    endtask

    task automatic clear_size_line();
        line_len = '0;
        size_acc = '0;
        held_char = '0;
        bad_digit = 1'b0;
    endtask

    task automatic end_body(input logic [2:0] code);
        dec_phase = hcbd_pkg::PH_DONE;
        end_status = code;
    endtask

    task automatic decode_byte(input logic [7:0] b, output hcbd_pkg::result_t r);
        logic [32:0] sum;
        logic [3:0]  digit;
        r = '0;
        if (dec_phase == hcbd_pkg::PH_SIZE)
        begin
            if (b == hcbd_pkg::CHAR_LF)
            begin
                if (line_len <= 1)
                    clear_size_line();
                else if (bad_digit)
                    end_body(hcbd_pkg::ST_HEX);
                else if (size_acc == '0)
                    end_body(total_len == '0 ? hcbd_pkg::ST_EMPTY : hcbd_pkg::ST_DATA);
                else
                begin
                    sum = {1'b0, total_len} + {5'b0, size_acc};
                    total_len = sum[32] ? 32'hFFFF_FFFF : sum[31:0];
                    if (sum > {1'b0, limit_reg})
                        end_body(hcbd_pkg::ST_BIG);
                    else
                    begin
                        chunk_left = size_acc;
                        clear_size_line();
                        dec_phase = hcbd_pkg::PH_DATA;
                    end
                end
            end
            else if (line_len >= LINE_LIMIT)
                end_body(hcbd_pkg::ST_LONG);
            else
            begin
                if (line_len > 0)
                begin
                    digit = 4'd0;
                    if (held_char >= 8'h30 && held_char <= 8'h39)
                        digit = held_char[3:0];
                    else if ((held_char >= 8'h61 && held_char <= 8'h66) ||
                             (held_char >= 8'h41 && held_char <= 8'h46))
                        digit = held_char[3:0] + 4'd9;
                    else
                        bad_digit = 1'b1;
                    size_acc = {size_acc[23:0], digit};
                end
                held_char = b;
                line_len = line_len + 5'd1;
            end
        end
        else if (dec_phase == hcbd_pkg::PH_DATA)
        begin
            r.payload_byte = b;
            r.payload_valid = 1'b1;
            chunk_left = chunk_left - 28'd1;
            if (chunk_left == '0)
                dec_phase = hcbd_pkg::PH_SIZE;
        end
        if (dec_phase == hcbd_pkg::PH_DONE)
        begin
            r.status = end_status;
            r.finished = 1'b1;
        end
        else
        begin
            r.status = hcbd_pkg::ST_BUSY;
            r.finished = 1'b0;
        end
    endtask

    task automatic add_byte(input logic [7:0] b);
        body_stream.push_back('{OP_BYTE, {24'h0, b}});
        body_bytes++;
    endtask

    task automatic add_limit(input logic [31:0] v);
        body_stream.push_back('{OP_DRAIN, 32'h0});
        body_stream.push_back('{OP_LIMIT, v});
    endtask

    function automatic logic [7:0] random_non_lf();
        logic [7:0] b;
        do
            b = 8'($urandom_range(0, 255));
        while (b == hcbd_pkg::CHAR_LF);
        return b;
    endfunction

    // Size line: optional leading zeros, hex digits in random case, a dropped tail
    // character and the LF. A negative pad picks the padding at random.
    task automatic add_size_line(input int unsigned size, input int pad, input logic [7:0] tail);
        int          ndig;
        int unsigned rest;
        logic [3:0]  d;
        ndig = 0;
        rest = size;
        do
        begin
            ndig++;
            rest = rest >> 4;
        end
        while (rest != 0);
        if (pad < 0)
            pad = ($urandom_range(0, 3) == 0) ? $urandom_range(0, LINE_LIMIT - 1 - ndig) : 0;
        repeat (pad)
            add_byte(8'h30);
        for (int i = ndig - 1; i >= 0; i--)
        begin
            d = 4'(size >> (4 * i));
            if (d < 10)
                add_byte(8'h30 + d);
            else
                add_byte(($urandom_range(0, 1) ? 8'h41 : 8'h61) + d - 8'd10);
        end
        add_byte(tail);
        add_byte(hcbd_pkg::CHAR_LF);
        gen_total += size;
    endtask

    task automatic add_chunk(input int unsigned size);
        add_size_line(size, -1, ($urandom_range(0, 4) == 0) ? random_non_lf() : 8'h0D);
        repeat (size)
            add_byte(8'($urandom_range(0, 255)));
        case ($urandom_range(0, 3))
            0, 1:
            begin
                add_byte(8'h0D);
                add_byte(hcbd_pkg::CHAR_LF);
            end
            2: add_byte(hcbd_pkg::CHAR_LF);
            default: ;
        endcase
    endtask

    // Sender: offers bytes and limit writes from the stimulus queue.
    always @(posedge clk)
    begin : sender
        logic        nxt_push;
        logic [7:0]  nxt_byte;
        logic        nxt_cfg_valid;
        logic [31:0] nxt_cfg_data;
        if (rst_n)
        begin
            nxt_push = push;
            nxt_byte = rx_byte;
            nxt_cfg_valid = cfg_valid;
            nxt_cfg_data = cfg_data;
            if (push && !full)
                nxt_push = 1'b0;
            if (cfg_valid && cfg_ready)
                nxt_cfg_valid = 1'b0;
            if (!nxt_push && !nxt_cfg_valid)
            begin
                if (send_gap > 0)
                    send_gap--;
                else if (body_stream.size() > 0)
                begin
                    case (body_stream[0].kind)
                        OP_BYTE:
                        begin
                            if (!quiet_tail && $urandom_range(0, 7) == 0)
                                send_gap = $urandom_range(0, 8);
                            else
                            begin
                                nxt_push = 1'b1;
                                nxt_byte = body_stream[0].value[7:0];
                                body_stream.pop_front();
                            end
                        end
                        OP_DRAIN:
                        begin
                            if (pending_results.size() == 0 && !push)
                                body_stream.pop_front();
                        end
                        default:
                        begin
                            nxt_cfg_valid = 1'b1;
                            nxt_cfg_data = body_stream[0].value;
                            body_stream.pop_front();
                        end
                    endcase
                end
            end
            push <= nxt_push;
            rx_byte <= nxt_byte;
            cfg_valid <= nxt_cfg_valid;
            cfg_data <= nxt_cfg_data;
            quiet_tail <= (body_stream.size() < 200);
        end
    end

    // Receiver: pops at random, with one long hold-off so the block backs up.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (pop && !empty)
                pops_seen++;
            if (recv_wait > 0)
            begin
                recv_wait--;
                pop <= 1'b0;
            end
            else if (pops_seen >= HOLD_AFTER_POPS && !held_once)
            begin
                held_once = 1'b1;
                recv_wait = HOLD_CYCLES - 1;
                pop <= 1'b0;
            end
            else if (!quiet_tail && $urandom_range(0, 7) == 0)
            begin
                recv_wait = $urandom_range(0, 8);
                pop <= 1'b0;
            end
            else
                pop <= 1'b1;
        end
    end

    always @(posedge clk)
    begin : monitor
        hcbd_pkg::result_t got;
        hcbd_pkg::result_t want;
        if (rst_n)
        begin
            if ((push && !full) || (pop && !empty) || (cfg_valid && cfg_ready))
                stall_cycles = 0;
            else
                stall_cycles++;
            if (cfg_valid && cfg_ready)
                limit_reg = cfg_data;
            if (push && !full)
            begin
                decode_byte(rx_byte, want);
                pending_results.push_back(want);
            end
            if (pop && !empty)
            begin
                got = '{payload_byte, payload_valid, status, finished};
                if (pending_results.size() == 0)
                    report_mismatch("result with none pending", {19'h0, got}, 32'h0);
                else
                begin
                    want = pending_results.pop_front();
                    if (got.payload_byte !== want.payload_byte)
                        report_mismatch("payload_byte", got.payload_byte, want.payload_byte);
                    if (got.payload_valid !== want.payload_valid)
                        report_mismatch("payload_valid", got.payload_valid, want.payload_valid);
                    if (got.status !== want.status)
                        report_mismatch("status", got.status, want.status);
                    if (got.finished !== want.finished)
                        report_mismatch("finished", got.finished, want.finished);
                end
            end
        end
    end

    initial
    begin
        while (stall_cycles < STALL_LIMIT)
            @(posedge clk);
        $display("http_chunked_body_decoder_tb: done, errors");
        $finish;
    end

    initial
    begin
        int unsigned size;
        logic [7:0]  bad;

        // Empty lines of zero and one character, a one-byte chunk under the reset limit,
        // then a full-length size line with edge-value payload.
        add_byte(hcbd_pkg::CHAR_LF);
        add_byte(8'hFF);
        add_byte(hcbd_pkg::CHAR_LF);
        add_size_line(1, 0, 8'h0D);
        add_byte(8'h00);
        add_byte(8'h0D);
        add_byte(hcbd_pkg::CHAR_LF);
        add_limit(32'hFFFF_FFFF);
        add_size_line(3, LINE_LIMIT - 2, 8'h0D);
        add_byte(8'hFF);
        add_byte(hcbd_pkg::CHAR_LF);
        add_byte(8'h80);
        add_byte(hcbd_pkg::CHAR_LF);

        while (body_bytes < BODY_ITEMS - 20)
        begin
            case ($urandom_range(0, 19))
                0:
                begin
                    if ($urandom_range(0, 1))
                        add_byte(random_non_lf());
                    add_byte(hcbd_pkg::CHAR_LF);
                end
                1: add_limit($urandom_range(32'hFFFF_FFFF, gen_total + 2000));
                2:
                begin
                    size = $urandom_range(1, 16);
                    add_limit(gen_total + size);
                    add_chunk(size);
                end
                default:
                begin
                    size = ($urandom_range(0, 7) == 0) ? $urandom_range(17, 64)
                                                       : $urandom_range(1, 16);
                    add_chunk(size);
                end
            endcase
        end

        // The body ends one way per run; the seed picks which.
        case ($urandom_range(0, 3))
            0:
            begin
                add_limit(32'h0);
                add_size_line(0, -1, 8'h0D);
            end
            1:
            begin
                size = $urandom_range(1, 8);
                add_limit(gen_total + size);
                add_chunk(size);
                if ($urandom_range(0, 1))
                    add_limit(32'h0);
                add_size_line($urandom_range(1, 28'hFFF_FFFF), -1, 8'h0D);
            end
            2:
            begin
                repeat (LINE_LIMIT + 1)
                    add_byte(random_non_lf());
            end
            default:
            begin
                do
                    bad = random_non_lf();
                while ((bad >= 8'h30 && bad <= 8'h39) || (bad >= 8'h41 && bad <= 8'h46) ||
                       (bad >= 8'h61 && bad <= 8'h66));
                if ($urandom_range(0, 1))
                    add_byte(8'h31);
                add_byte(bad);
                add_byte(8'h0D);
                add_byte(hcbd_pkg::CHAR_LF);
            end
        endcase
        repeat (20)
            add_byte(8'($urandom_range(0, 255)));

        repeat (8)
            @(posedge clk);
        rst_n <= 1'b1;

        while (body_stream.size() != 0 || push || cfg_valid || pending_results.size() != 0)
            @(posedge clk);
        repeat (8)
            @(posedge clk);
        if (pending_results.size() != 0)
            report_mismatch("results never delivered", pending_results.size(), 0);
        if (fault_count == 0)
            $display("http_chunked_body_decoder_tb: done, clean");
        else
            $display("http_chunked_body_decoder_tb: done, errors");
        $finish;
    end

endmodule
